/* sv/bfha_pkg.sv */
// types, constants and codes shared by the best-fit heap allocator
// no dependencies; imported by bfha_hdr_ram and best_fit_heap_allocator_top
package bfha_pkg;

    localparam int OFF_W      = 16;
    localparam int ZB_W       = 17;
    localparam int ALIGN_SH   = 2;
    localparam int ALIGN      = 1 << ALIGN_SH;
    localparam int IDX_W      = OFF_W - ALIGN_SH;
    localparam int ZONE_HDR   = 16;
    localparam int BLK_HDR    = 16;
    localparam int MAX_ZONE   = 65536;
    localparam int MIN_ZONE   = ZONE_HDR + BLK_HDR;

    // operation codes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_REALLOC = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOSPACE   = 2'd1;
    localparam logic [1:0] STAT_BADHANDLE = 2'd2;

    // one block header tag
    typedef struct packed {
        logic             valid;
        logic             inuse;
        logic [OFF_W-1:0] size;
        logic [OFF_W-1:0] prev;
    } hdr_t;

    // header memory request: write enable, write address and data, read address
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        hdr_t             wdata;
        logic [IDX_W-1:0] raddr;
    } hdr_req_t;

    typedef enum logic [5:0] {
        S_CLEAR, S_INIT, S_IDLE, S_CHK, S_DONE,
        S_AL0, S_AL1, S_AL_END, S_AL2, S_AL3, S_AL_RES,
        S_SP0, S_SP1, S_SP2, S_SP3,
        S_AB0, S_AB1, S_AB2, S_AB3, S_AB4,
        S_FR0, S_FR1, S_FR2, S_FR3, S_FR4, S_FR5, S_FR6,
        S_RA_NX, S_RA_MV, S_RA_PV, S_RA_PF, S_RA_PI,
        S_GRANT_RD, S_GRANT
    } state_t;

endpackage

/* sv/bfha_hdr_ram.sv */
// header tag memory: one write port, one registered read port
// depends on bfha_pkg
module bfha_hdr_ram (
    input  logic              clk,
    input  bfha_pkg::hdr_req_t req,
    output bfha_pkg::hdr_t     rd_data
);
    import bfha_pkg::*;

    hdr_t mem [1 << IDX_W];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read port, registered: data appears in the cycle after the address
    always_ff @(posedge clk)
    begin
        rd_data <= mem[req.raddr];
    end

endmodule

/* sv/best_fit_heap_allocator_top.sv */
// best-fit heap allocator with boundary-tag coalescing over a header memory
// free coalesces with its neighbours; allocate walks each block in the zone, then splits and merges;
// reallocate adds up to one allocate and one free
// one item at a time, set by the single header memory read port walking the block chain
// after reset or a cfg_data write a clearing pass over every header runs; no item is taken
// depends on bfha_pkg and bfha_hdr_ram
module best_fit_heap_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] request_size,
    input  logic        handle_present,
    input  logic [15:0] block_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] result_offset,
    output logic [15:0] granted_size,
    output logic        data_moved,
    output logic [15:0] old_payload_bytes
);
    import bfha_pkg::*;

    function automatic logic [ZB_W-1:0] next_off(input logic [OFF_W-1:0] off,
                                                 input logic [OFF_W-1:0] sz);
        return {1'b0, off} + ZB_W'(BLK_HDR) + {1'b0, sz};
    endfunction

    function automatic logic [OFF_W-1:0] next_off16(input logic [OFF_W-1:0] off,
                                                    input logic [OFF_W-1:0] sz);
        logic [ZB_W-1:0] t;
        t = next_off(off, sz);
        return t[OFF_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] idx(input logic [OFF_W-1:0] off);
        return off[OFF_W-1:ALIGN_SH];
    endfunction

    hdr_req_t mem_req;
    hdr_t     mem_q;

    bfha_hdr_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_q)
    );

    // control state
    state_t            state_reg, state_next;
    logic [ZB_W-1:0]   zone_end_reg, zone_end_next;
    logic [OFF_W-1:0]  tail_reg, tail_next;
    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic              out_valid_reg, out_valid_next;

    // item and working registers
    logic [1:0]        op_reg, op_next;
    logic [OFF_W-1:0]  req_reg, req_next;
    logic [ZB_W-1:0]   r_reg, r_next;
    logic [OFF_W-1:0]  boff_reg, boff_next;
    hdr_t              hb_reg, hb_next;
    logic              nx_reg, nx_next;
    logic [OFF_W-1:0]  fnx_reg, fnx_next;
    logic [OFF_W-1:0]  grant_reg, grant_next;

    logic [OFF_W-1:0]  fr_off_reg, fr_off_next;
    hdr_t              fr_h_reg, fr_h_next;
    state_t            fr_ret_reg, fr_ret_next;
    logic [OFF_W-1:0]  cur_reg, cur_next;
    logic [OFF_W-1:0]  cur_size_reg, cur_size_next;

    logic [OFF_W-1:0]  ab_off_reg, ab_off_next;
    hdr_t              ab_h_reg, ab_h_next;
    logic [OFF_W-1:0]  ab_f_reg, ab_f_next;
    logic [OFF_W-1:0]  ab_g_reg, ab_g_next;
    logic              ab_ftail_reg, ab_ftail_next;
    state_t            ab_ret_reg, ab_ret_next;

    logic [OFF_W-1:0]  sp_off_reg, sp_off_next;
    logic [OFF_W-1:0]  sp_size_reg, sp_size_next;
    logic [OFF_W-1:0]  sp_rem_reg, sp_rem_next;
    logic [OFF_W-1:0]  sp_n_reg, sp_n_next;
    logic [OFF_W-1:0]  sp_f_reg, sp_f_next;
    logic              sp_tail_reg, sp_tail_next;
    state_t            sp_ret_reg, sp_ret_next;

    logic [ZB_W-1:0]   al_off_reg, al_off_next;
    logic [OFF_W-1:0]  al_best_reg, al_best_next;
    logic [OFF_W-1:0]  al_bsize_reg, al_bsize_next;
    logic              al_found_reg, al_found_next;
    logic              al_ok_reg, al_ok_next;
    logic [OFF_W-1:0]  al_got_reg, al_got_next;
    logic [OFF_W-1:0]  al_gsz_reg, al_gsz_next;
    state_t            al_ret_reg, al_ret_next;

    logic [1:0]        res_status_reg, res_status_next;
    logic [OFF_W-1:0]  res_off_reg, res_off_next;
    logic [OFF_W-1:0]  res_gsize_reg, res_gsize_next;
    logic              res_moved_reg, res_moved_next;
    logic [OFF_W-1:0]  res_oldp_reg, res_oldp_next;

    logic [1:0]        out_status_reg, out_status_next;
    logic [OFF_W-1:0]  out_off_reg, out_off_next;
    logic [OFF_W-1:0]  out_gsize_reg, out_gsize_next;
    logic              out_moved_reg, out_moved_next;
    logic [OFF_W-1:0]  out_oldp_reg, out_oldp_next;

    // derived values
    logic              chk_live;
    logic [ZB_W-1:0]   cfg_zb;
    logic [ZB_W-1:0]   rem_w;
    logic [ZB_W-1:0]   grow_w;
    logic [ZB_W-1:0]   pmerge_w;
    logic              al_cand;

    assign chk_live = ({1'b0, boff_reg} < zone_end_reg) && (boff_reg[ALIGN_SH-1:0] == '0)
                      && mem_q.valid && mem_q.inuse;
    assign cfg_zb   = (cfg_data < ZB_W'(MIN_ZONE)) ? ZB_W'(MIN_ZONE) :
                      (cfg_data > ZB_W'(MAX_ZONE)) ? ZB_W'(MAX_ZONE) : cfg_data;
    assign rem_w    = {1'b0, mem_q.size} - {1'b0, sp_size_reg};
    assign grow_w   = {1'b0, hb_reg.size} + {1'b0, mem_q.size} + ZB_W'(BLK_HDR);
    assign pmerge_w = grow_w;
    assign al_cand  = !mem_q.inuse && ({1'b0, mem_q.size} >= r_reg)
                      && (!al_found_reg || (mem_q.size < al_bsize_reg));

    // sequencer: next state, memory accesses and working registers
    always_comb
    begin
        state_next     = state_reg;
        zone_end_next  = zone_end_reg;
        tail_next      = tail_reg;
        clr_idx_next   = clr_idx_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        req_next       = req_reg;
        r_next         = r_reg;
        boff_next      = boff_reg;
        hb_next        = hb_reg;
        nx_next        = nx_reg;
        fnx_next       = fnx_reg;
        grant_next     = grant_reg;
        fr_off_next    = fr_off_reg;
        fr_h_next      = fr_h_reg;
        fr_ret_next    = fr_ret_reg;
        cur_next       = cur_reg;
        cur_size_next  = cur_size_reg;
        ab_off_next    = ab_off_reg;
        ab_h_next      = ab_h_reg;
        ab_f_next      = ab_f_reg;
        ab_g_next      = ab_g_reg;
        ab_ftail_next  = ab_ftail_reg;
        ab_ret_next    = ab_ret_reg;
        sp_off_next    = sp_off_reg;
        sp_size_next   = sp_size_reg;
        sp_rem_next    = sp_rem_reg;
        sp_n_next      = sp_n_reg;
        sp_f_next      = sp_f_reg;
        sp_tail_next   = sp_tail_reg;
        sp_ret_next    = sp_ret_reg;
        al_off_next    = al_off_reg;
        al_best_next   = al_best_reg;
        al_bsize_next  = al_bsize_reg;
        al_found_next  = al_found_reg;
        al_ok_next     = al_ok_reg;
        al_got_next    = al_got_reg;
        al_gsz_next    = al_gsz_reg;
        al_ret_next    = al_ret_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_gsize_next  = res_gsize_reg;
        res_moved_next  = res_moved_reg;
        res_oldp_next   = res_oldp_reg;
        out_status_next = out_status_reg;
        out_off_next    = out_off_reg;
        out_gsize_next  = out_gsize_reg;
        out_moved_next  = out_moved_reg;
        out_oldp_next   = out_oldp_reg;
        mem_req         = '0;

        // output beat taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // clearing pass over the header memory
            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_idx_reg;
                mem_req.wdata = '0;
                clr_idx_next  = clr_idx_reg + 1'b1;
                if (clr_idx_reg == '1)
                begin
                    state_next = S_INIT;
                end
            end

            // one free block spanning the zone
            S_INIT:
            begin
                mem_req.we          = 1'b1;
                mem_req.waddr       = idx(OFF_W'(ZONE_HDR));
                mem_req.wdata.valid = 1'b1;
                mem_req.wdata.inuse = 1'b0;
                mem_req.wdata.size  = OFF_W'(zone_end_reg - ZB_W'(MIN_ZONE));
                mem_req.wdata.prev  = '0;
                tail_next           = OFF_W'(ZONE_HDR);
                state_next          = S_IDLE;
            end

            // take an item, read the named header on the way
            S_IDLE:
            begin
                mem_req.raddr = idx(block_offset);
                if (in_valid)
                begin
                    op_next         = operation;
                    req_next        = request_size;
                    r_next          = ({1'b0, request_size} + ZB_W'(ALIGN - 1))
                                      & ~ZB_W'(ALIGN - 1);
                    boff_next       = block_offset;
                    res_status_next = STAT_OK;
                    res_off_next    = '0;
                    res_gsize_next  = '0;
                    res_moved_next  = 1'b0;
                    res_oldp_next   = '0;
                    case (operation)
                        OP_ALLOC:
                        begin
                            al_ret_next = S_AL_RES;
                            state_next  = S_AL0;
                        end
                        OP_FREE:
                        begin
                            state_next = handle_present ? S_CHK : S_DONE;
                        end
                        OP_REALLOC:
                        begin
                            al_ret_next = S_AL_RES;
                            state_next  = handle_present ? S_CHK : S_AL0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // handle check and dispatch of free and reallocate
            S_CHK:
            begin
                if (!chk_live)
                begin
                    res_status_next = STAT_BADHANDLE;
                    state_next      = S_DONE;
                end
                else if (op_reg == OP_FREE)
                begin
                    fr_off_next = boff_reg;
                    fr_ret_next = S_DONE;
                    state_next  = S_FR0;
                end
                else
                begin
                    hb_next       = mem_q;
                    res_oldp_next = mem_q.size;
                    nx_next       = (boff_reg != tail_reg);
                    fnx_next      = next_off16(boff_reg, mem_q.size);
                    if (req_reg == '0)
                    begin
                        fr_off_next = boff_reg;
                        fr_ret_next = S_AL0;
                        al_ret_next = S_AL_RES;
                        state_next  = S_FR0;
                    end
                    else if ({1'b0, mem_q.size} >= r_reg)
                    begin
                        sp_off_next  = boff_reg;
                        sp_size_next = r_reg[OFF_W-1:0];
                        sp_ret_next  = S_GRANT_RD;
                        grant_next   = boff_reg;
                        state_next   = S_SP0;
                    end
                    else if (boff_reg != tail_reg)
                    begin
                        mem_req.raddr = idx(next_off16(boff_reg, mem_q.size));
                        state_next    = S_RA_NX;
                    end
                    else
                    begin
                        al_ret_next = S_RA_MV;
                        state_next  = S_AL0;
                    end
                end
            end

            // grow into a free successor, else move
            S_RA_NX:
            begin
                if (!mem_q.inuse && (grow_w >= r_reg))
                begin
                    ab_off_next  = boff_reg;
                    ab_ret_next  = S_SP0;
                    sp_off_next  = boff_reg;
                    sp_size_next = r_reg[OFF_W-1:0];
                    sp_ret_next  = S_GRANT_RD;
                    grant_next   = boff_reg;
                    state_next   = S_AB0;
                end
                else
                begin
                    al_ret_next = S_RA_MV;
                    state_next  = S_AL0;
                end
            end

            // moved to a new block, else try the predecessor
            S_RA_MV:
            begin
                if (al_ok_reg)
                begin
                    res_off_next   = al_got_reg;
                    res_gsize_next = al_gsz_reg;
                    res_moved_next = 1'b1;
                    fr_off_next    = boff_reg;
                    fr_ret_next    = S_DONE;
                    state_next     = S_FR0;
                end
                else if (boff_reg != OFF_W'(ZONE_HDR))
                begin
                    mem_req.raddr = idx(hb_reg.prev);
                    state_next    = S_RA_PV;
                end
                else
                begin
                    res_status_next = STAT_NOSPACE;
                    state_next      = S_DONE;
                end
            end

            // merge into a free predecessor
            S_RA_PV:
            begin
                if (!mem_q.inuse && (pmerge_w >= r_reg))
                begin
                    mem_req.we          = 1'b1;
                    mem_req.waddr       = idx(hb_reg.prev);
                    mem_req.wdata.valid = 1'b1;
                    mem_req.wdata.inuse = 1'b1;
                    mem_req.wdata.size  = pmerge_w[OFF_W-1:0];
                    mem_req.wdata.prev  = mem_q.prev;
                    if (nx_reg)
                    begin
                        mem_req.raddr = idx(fnx_reg);
                        state_next    = S_RA_PF;
                    end
                    else
                    begin
                        tail_next  = hb_reg.prev;
                        state_next = S_RA_PI;
                    end
                end
                else
                begin
                    res_status_next = STAT_NOSPACE;
                    state_next      = S_DONE;
                end
            end

            S_RA_PF:
            begin
                mem_req.we         = 1'b1;
                mem_req.waddr      = idx(fnx_reg);
                mem_req.wdata      = mem_q;
                mem_req.wdata.prev = hb_reg.prev;
                state_next         = S_RA_PI;
            end

            S_RA_PI:
            begin
                mem_req.we     = 1'b1;
                mem_req.waddr  = idx(boff_reg);
                mem_req.wdata  = '0;
                sp_off_next    = hb_reg.prev;
                sp_size_next   = r_reg[OFF_W-1:0];
                sp_ret_next    = S_GRANT_RD;
                grant_next     = hb_reg.prev;
                res_moved_next = 1'b1;
                state_next     = S_SP0;
            end

            // report the granted block
            S_GRANT_RD:
            begin
                mem_req.raddr = idx(grant_reg);
                state_next    = S_GRANT;
            end

            S_GRANT:
            begin
                res_off_next   = grant_reg;
                res_gsize_next = mem_q.size;
                state_next     = S_DONE;
            end

            S_AL_RES:
            begin
                if (al_ok_reg)
                begin
                    res_off_next   = al_got_reg;
                    res_gsize_next = al_gsz_reg;
                end
                else
                begin
                    res_status_next = STAT_NOSPACE;
                end
                state_next = S_DONE;
            end

            // best-fit walk of the block chain
            S_AL0:
            begin
                if ({1'b0, req_reg} > zone_end_reg)
                begin
                    al_ok_next = 1'b0;
                    state_next = al_ret_reg;
                end
                else
                begin
                    al_off_next   = ZB_W'(ZONE_HDR);
                    al_found_next = 1'b0;
                    mem_req.raddr = idx(OFF_W'(ZONE_HDR));
                    state_next    = S_AL1;
                end
            end

            S_AL1:
            begin
                if ((al_off_reg < zone_end_reg) && mem_q.valid)
                begin
                    if (al_cand)
                    begin
                        al_best_next  = al_off_reg[OFF_W-1:0];
                        al_bsize_next = mem_q.size;
                        al_found_next = 1'b1;
                    end
                    if (al_off_reg[OFF_W-1:0] == tail_reg)
                    begin
                        state_next = S_AL_END;
                    end
                    else
                    begin
                        al_off_next   = next_off(al_off_reg[OFF_W-1:0], mem_q.size);
                        mem_req.raddr = idx(next_off16(al_off_reg[OFF_W-1:0], mem_q.size));
                    end
                end
                else
                begin
                    state_next = S_AL_END;
                end
            end

            S_AL_END:
            begin
                if (al_found_reg)
                begin
                    sp_off_next  = al_best_reg;
                    sp_size_next = r_reg[OFF_W-1:0];
                    sp_ret_next  = S_AL2;
                    state_next   = S_SP0;
                end
                else
                begin
                    al_ok_next = 1'b0;
                    state_next = al_ret_reg;
                end
            end

            S_AL2:
            begin
                mem_req.raddr = idx(al_best_reg);
                state_next    = S_AL3;
            end

            S_AL3:
            begin
                mem_req.we          = 1'b1;
                mem_req.waddr       = idx(al_best_reg);
                mem_req.wdata       = mem_q;
                mem_req.wdata.inuse = 1'b1;
                al_got_next         = al_best_reg;
                al_gsz_next         = mem_q.size;
                al_ok_next          = 1'b1;
                state_next          = al_ret_reg;
            end

            // split off the leftover as a free block
            S_SP0:
            begin
                mem_req.raddr = idx(sp_off_reg);
                state_next    = S_SP1;
            end

            S_SP1:
            begin
                if (rem_w <= ZB_W'(BLK_HDR))
                begin
                    state_next = sp_ret_reg;
                end
                else
                begin
                    mem_req.we         = 1'b1;
                    mem_req.waddr      = idx(sp_off_reg);
                    mem_req.wdata      = mem_q;
                    mem_req.wdata.size = sp_size_reg;
                    sp_rem_next        = rem_w[OFF_W-1:0];
                    sp_n_next          = next_off16(sp_off_reg, sp_size_reg);
                    sp_f_next          = next_off16(sp_off_reg, mem_q.size);
                    sp_tail_next       = (sp_off_reg == tail_reg);
                    state_next         = S_SP2;
                end
            end

            S_SP2:
            begin
                mem_req.we          = 1'b1;
                mem_req.waddr       = idx(sp_n_reg);
                mem_req.wdata.valid = 1'b1;
                mem_req.wdata.inuse = 1'b0;
                mem_req.wdata.size  = sp_rem_reg - OFF_W'(BLK_HDR);
                mem_req.wdata.prev  = sp_off_reg;
                if (sp_tail_reg)
                begin
                    tail_next  = sp_n_reg;
                    state_next = sp_ret_reg;
                end
                else
                begin
                    mem_req.raddr = idx(sp_f_reg);
                    state_next    = S_SP3;
                end
            end

            S_SP3:
            begin
                mem_req.we         = 1'b1;
                mem_req.waddr      = idx(sp_f_reg);
                mem_req.wdata      = mem_q;
                mem_req.wdata.prev = sp_n_reg;
                if (!mem_q.inuse)
                begin
                    ab_off_next = sp_n_reg;
                    ab_ret_next = sp_ret_reg;
                    state_next  = S_AB0;
                end
                else
                begin
                    state_next = sp_ret_reg;
                end
            end

            // absorb the successor
            S_AB0:
            begin
                mem_req.raddr = idx(ab_off_reg);
                state_next    = S_AB1;
            end

            S_AB1:
            begin
                ab_h_next     = mem_q;
                ab_f_next     = next_off16(ab_off_reg, mem_q.size);
                mem_req.raddr = idx(next_off16(ab_off_reg, mem_q.size));
                state_next    = S_AB2;
            end

            S_AB2:
            begin
                mem_req.we         = 1'b1;
                mem_req.waddr      = idx(ab_off_reg);
                mem_req.wdata      = ab_h_reg;
                mem_req.wdata.size = next_off16(ab_h_reg.size, mem_q.size);
                ab_g_next          = next_off16(ab_f_reg, mem_q.size);
                ab_ftail_next      = (ab_f_reg == tail_reg);
                state_next         = S_AB3;
            end

            S_AB3:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx(ab_f_reg);
                mem_req.wdata = '0;
                if (ab_ftail_reg)
                begin
                    tail_next  = ab_off_reg;
                    state_next = ab_ret_reg;
                end
                else
                begin
                    mem_req.raddr = idx(ab_g_reg);
                    state_next    = S_AB4;
                end
            end

            S_AB4:
            begin
                mem_req.we         = 1'b1;
                mem_req.waddr      = idx(ab_g_reg);
                mem_req.wdata      = mem_q;
                mem_req.wdata.prev = ab_off_reg;
                state_next         = ab_ret_reg;
            end

            // free and coalesce with neighbours
            S_FR0:
            begin
                mem_req.raddr = idx(fr_off_reg);
                state_next    = S_FR1;
            end

            S_FR1:
            begin
                fr_h_next           = mem_q;
                mem_req.we          = 1'b1;
                mem_req.waddr       = idx(fr_off_reg);
                mem_req.wdata       = mem_q;
                mem_req.wdata.valid = 1'b1;
                mem_req.wdata.inuse = 1'b0;
                if (fr_off_reg != OFF_W'(ZONE_HDR))
                begin
                    mem_req.raddr = idx(mem_q.prev);
                    state_next    = S_FR2;
                end
                else
                begin
                    cur_next      = fr_off_reg;
                    cur_size_next = mem_q.size;
                    state_next    = S_FR5;
                end
            end

            S_FR2:
            begin
                if (!mem_q.inuse)
                begin
                    mem_req.we          = 1'b1;
                    mem_req.waddr       = idx(fr_h_reg.prev);
                    mem_req.wdata.valid = 1'b1;
                    mem_req.wdata.inuse = 1'b0;
                    mem_req.wdata.size  = next_off16(mem_q.size, fr_h_reg.size);
                    mem_req.wdata.prev  = mem_q.prev;
                    cur_next            = fr_h_reg.prev;
                    cur_size_next       = next_off16(mem_q.size, fr_h_reg.size);
                    if (fr_off_reg != tail_reg)
                    begin
                        mem_req.raddr = idx(next_off16(fr_off_reg, fr_h_reg.size));
                        state_next    = S_FR3;
                    end
                    else
                    begin
                        tail_next  = fr_h_reg.prev;
                        state_next = S_FR4;
                    end
                end
                else
                begin
                    cur_next      = fr_off_reg;
                    cur_size_next = fr_h_reg.size;
                    state_next    = S_FR5;
                end
            end

            S_FR3:
            begin
                mem_req.we         = 1'b1;
                mem_req.waddr      = idx(next_off16(fr_off_reg, fr_h_reg.size));
                mem_req.wdata      = mem_q;
                mem_req.wdata.prev = fr_h_reg.prev;
                state_next         = S_FR4;
            end

            S_FR4:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx(fr_off_reg);
                mem_req.wdata = '0;
                state_next    = S_FR5;
            end

            S_FR5:
            begin
                if (cur_reg != tail_reg)
                begin
                    mem_req.raddr = idx(next_off16(cur_reg, cur_size_reg));
                    state_next    = S_FR6;
                end
                else
                begin
                    state_next = fr_ret_reg;
                end
            end

            S_FR6:
            begin
                if (!mem_q.inuse)
                begin
                    ab_off_next = cur_reg;
                    ab_ret_next = fr_ret_reg;
                    state_next  = S_AB0;
                end
                else
                begin
                    state_next = fr_ret_reg;
                end
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_off_next    = res_off_reg;
                    out_gsize_next  = res_gsize_reg;
                    out_moved_next  = res_moved_reg;
                    out_oldp_next   = res_oldp_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // zone size write restarts the zone
        if (cfg_valid)
        begin
            zone_end_next = cfg_zb;
            clr_idx_next  = '0;
            state_next    = S_CLEAR;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            zone_end_reg  <= ZB_W'(MAX_ZONE);
            tail_reg      <= OFF_W'(ZONE_HDR);
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            zone_end_reg  <= zone_end_next;
            tail_reg      <= tail_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        req_reg        <= req_next;
        r_reg          <= r_next;
        boff_reg       <= boff_next;
        hb_reg         <= hb_next;
        nx_reg         <= nx_next;
        fnx_reg        <= fnx_next;
        grant_reg      <= grant_next;
        fr_off_reg     <= fr_off_next;
        fr_h_reg       <= fr_h_next;
        fr_ret_reg     <= fr_ret_next;
        cur_reg        <= cur_next;
        cur_size_reg   <= cur_size_next;
        ab_off_reg     <= ab_off_next;
        ab_h_reg       <= ab_h_next;
        ab_f_reg       <= ab_f_next;
        ab_g_reg       <= ab_g_next;
        ab_ftail_reg   <= ab_ftail_next;
        ab_ret_reg     <= ab_ret_next;
        sp_off_reg     <= sp_off_next;
        sp_size_reg    <= sp_size_next;
        sp_rem_reg     <= sp_rem_next;
        sp_n_reg       <= sp_n_next;
        sp_f_reg       <= sp_f_next;
        sp_tail_reg    <= sp_tail_next;
        sp_ret_reg     <= sp_ret_next;
        al_off_reg     <= al_off_next;
        al_best_reg    <= al_best_next;
        al_bsize_reg   <= al_bsize_next;
        al_found_reg   <= al_found_next;
        al_ok_reg      <= al_ok_next;
        al_got_reg     <= al_got_next;
        al_gsz_reg     <= al_gsz_next;
        al_ret_reg     <= al_ret_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_gsize_reg  <= res_gsize_next;
        res_moved_reg  <= res_moved_next;
        res_oldp_reg   <= res_oldp_next;
        out_status_reg <= out_status_next;
        out_off_reg    <= out_off_next;
        out_gsize_reg  <= out_gsize_next;
        out_moved_reg  <= out_moved_next;
        out_oldp_reg   <= out_oldp_next;
    end

    // ports
    assign cfg_ready         = 1'b1;
    assign in_stall          = (state_reg != S_IDLE);
    assign out_valid         = out_valid_reg;
    assign status            = out_status_reg;
    assign result_offset     = out_off_reg;
    assign granted_size      = out_gsize_reg;
    assign data_moved        = out_moved_reg;
    assign old_payload_bytes = out_oldp_reg;

`ifndef SYNTHESIS
    // a new output beat only comes from the hand-off state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("output beat raised outside hand-off");

    // the tail block always sits on an aligned header past the zone header
    a_tail_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg[ALIGN_SH-1:0] == '0) && (tail_reg >= OFF_W'(ZONE_HDR)))
        else $error("tail block offset misaligned");

    // outside the clearing pass, no header is read in the cycle it is rewritten
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.we && (state_reg != S_CLEAR)) |-> (mem_req.waddr != mem_req.raddr))
        else $error("header read and write to the same entry");
`endif

endmodule
